// File: hw/rtl/ckm_pkg.sv
package ckm_pkg;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int CHAN_W  = 8;
  localparam int EM_W    = CHAN_W - 3;
  localparam int NUM_CH  = 3;
  localparam int PF_W    = CHAN_W + EM_W;
  localparam int PB_W    = 2 * CHAN_W;
  localparam logic [CHAN_W-1:0] TOL_FULL = 8'hFF;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  typedef enum logic [2:0] {
    REG_SMOOTH_MODE = 3'd0,
    REG_KEY_RED     = 3'd1,
    REG_KEY_GREEN   = 3'd2,
    REG_KEY_BLUE    = 3'd3,
    REG_TOLERANCE   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_FG    = 2'd0,
    SEL_BG    = 2'd1,
    SEL_BLEND = 2'd2
  } sel_t;

  typedef struct packed {
    logic              smooth_mode;
    logic [CHAN_W-1:0] key_red;
    logic [CHAN_W-1:0] key_green;
    logic [CHAN_W-1:0] key_blue;
    logic [CHAN_W-1:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic [31:0] fg_pixel;
    logic [31:0] bg_pixel;
    logic        frame_end_in;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic        frame_end_out;
  } pix_out_t;

  typedef struct packed {
    logic [31:0]     fg;
    logic [31:0]     bg;
    logic            frame_end;
    logic [EM_W-1:0] em;
    sel_t            sel;
  } mid_t;

  function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: hw/rtl/ckm_regs.sv
module ckm_regs
  import ckm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SMOOTH_MODE: cfg.smooth_mode <= pwdata[0];
        REG_KEY_RED:     cfg.key_red     <= pwdata[CHAN_W-1:0];
        REG_KEY_GREEN:   cfg.key_green   <= pwdata[CHAN_W-1:0];
        REG_KEY_BLUE:    cfg.key_blue    <= pwdata[CHAN_W-1:0];
        REG_TOLERANCE:   cfg.tolerance   <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SMOOTH_MODE: prdata[0]          = cfg.smooth_mode;
      REG_KEY_RED:     prdata[CHAN_W-1:0] = cfg.key_red;
      REG_KEY_GREEN:   prdata[CHAN_W-1:0] = cfg.key_green;
      REG_KEY_BLUE:    prdata[CHAN_W-1:0] = cfg.key_blue;
      REG_TOLERANCE:   prdata[CHAN_W-1:0] = cfg.tolerance;
      default:         prdata             = '0;
    endcase
  end

endmodule

// File: hw/rtl/ckm_match.sv
module ckm_match
  import ckm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_stall,
  input  pix_in_t in_data,
  output logic    out_valid,
  input  logic    out_stall,
  output mid_t    out_data
);

  logic              a_valid;
  logic [31:0]       a_fg;
  logic [31:0]       a_bg;
  logic              a_fe;
  logic [CHAN_W-1:0] a_eb;
  logic [CHAN_W-1:0] a_eg;
  logic [CHAN_W-1:0] a_er;
  logic              en_a;
  logic              en_b;
  logic              match;
  logic [CHAN_W-1:0] emax;
  sel_t              sel;

  assign en_b     = !out_valid || !out_stall;
  assign en_a     = !a_valid || en_b;
  assign in_stall = !en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_fg <= in_data.fg_pixel;
      a_bg <= in_data.bg_pixel;
      a_fe <= in_data.frame_end_in;
      a_eb <= abs_diff(in_data.fg_pixel[7:0],   cfg.key_blue);
      a_eg <= abs_diff(in_data.fg_pixel[15:8],  cfg.key_green);
      a_er <= abs_diff(in_data.fg_pixel[23:16], cfg.key_red);
    end
  end

  always_comb begin
    match = (a_eb < cfg.tolerance) && (a_eg < cfg.tolerance) && (a_er < cfg.tolerance);
    emax  = a_eb;
    if (a_eg > emax) emax = a_eg;
    if (a_er > emax) emax = a_er;
    priority if (cfg.tolerance == TOL_FULL) begin
      sel = SEL_BG;
    end else if (!match) begin
      sel = SEL_FG;
    end else if (!cfg.smooth_mode) begin
      sel = SEL_BG;
    end else begin
      sel = SEL_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_b) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      out_data.fg        <= a_fg;
      out_data.bg        <= a_bg;
      out_data.frame_end <= a_fe;
      out_data.em        <= emax[CHAN_W-1:3];
      out_data.sel       <= sel;
    end
  end

endmodule

// File: hw/rtl/ckm_blend.sv
module ckm_blend
  import ckm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  mid_t     in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pix_out_t out_data
);

  logic              c_valid;
  mid_t              c_mid;
  logic [PF_W-1:0]   c_pf [NUM_CH];
  logic [PB_W-1:0]   c_pb [NUM_CH];
  logic [CHAN_W-1:0] inv_em;
  logic [PB_W-1:0]   sum  [NUM_CH];
  logic [31:0]       blended;
  logic [31:0]       pixel;
  logic              en_c;
  logic              en_d;

  assign en_d     = !out_valid || !out_stall;
  assign en_c     = !c_valid || en_d;
  assign in_stall = !en_c;
  assign inv_em   = CHAN_MAX - CHAN_W'(in_data.em);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && in_valid) begin
      c_mid <= in_data;
      for (int i = 0; i < NUM_CH; i++) begin
        c_pf[i] <= PF_W'(in_data.fg[CHAN_W*i +: CHAN_W]) * PF_W'(in_data.em);
        c_pb[i] <= PB_W'(in_data.bg[CHAN_W*i +: CHAN_W]) * PB_W'(inv_em);
      end
    end
  end

  always_comb begin
    blended = c_mid.fg;
    for (int i = 0; i < NUM_CH; i++) begin
      sum[i] = PB_W'(c_pf[i]) + c_pb[i] + PB_W'(CHAN_MAX);
      blended[CHAN_W*i +: CHAN_W] = sum[i][PB_W-1:CHAN_W];
    end
    unique case (c_mid.sel)
      SEL_FG:    pixel = c_mid.fg;
      SEL_BG:    pixel = c_mid.bg;
      SEL_BLEND: pixel = blended;
      default:   pixel = c_mid.fg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_d) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_valid) begin
      out_data.out_pixel     <= pixel;
      out_data.frame_end_out <= c_mid.frame_end;
    end
  end

endmodule

// File: hw/rtl/chroma_key_pixel_mixer.sv
// Channel   Direction  Handshake          Payload
// src       in         src_valid/stall    pix_in_t  (fg_pixel, bg_pixel, frame_end_in)
// dst       out        dst_valid/stall    pix_out_t (out_pixel, frame_end_out)
// apb       in/out     psel/penable       paddr, pwdata, prdata (5 registers)
//
// One pixel per clock while dst_stall is low.
// Stages: channel differences, match and blend weight, products, sum and select.
// Synchronous active-high reset clears valid bits and configuration registers to zero.
// A dst stall holds the output; upstream stages keep filling bubbles before
// src_stall rises.
module chroma_key_pixel_mixer
  import ckm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              src_valid,
  output logic              src_stall,
  input  pix_in_t           src_data,
  output logic              dst_valid,
  input  logic              dst_stall,
  output pix_out_t          dst_data
);

  cfg_t cfg;
  logic mid_valid;
  logic mid_stall;
  mid_t mid_data;

  ckm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ckm_match u_match (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (src_valid),
    .in_stall  (src_stall),
    .in_data   (src_data),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_data  (mid_data)
  );

  ckm_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_data   (mid_data),
    .out_valid (dst_valid),
    .out_stall (dst_stall),
    .out_data  (dst_data)
  );

endmodule

// File: hw/rtl/ckm_checker.sv
module ckm_checker
  import ckm_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     src_valid,
  input logic     src_stall,
  input pix_in_t  src_data,
  input logic     dst_valid,
  input logic     dst_stall,
  input pix_out_t dst_data
);

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("dst transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("dst valid after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!dst_valid || !dst_stall) |-> !src_stall)
    else $error("src stalled while output can drain");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (src_valid && !src_stall) ##1 !dst_stall ##1 !dst_stall ##1 !dst_stall
    |=> dst_valid && dst_data.frame_end_out == $past(src_data.frame_end_in, 4))
    else $error("transaction lost or frame end misaligned");

endmodule

bind chroma_key_pixel_mixer ckm_checker u_ckm_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_data  (src_data),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);
